// File: rtl/spm_pkg.sv
// spm_pkg: widths, constants and types shared by the stereo peak-hold meter
// no dependencies; imported by every other file of the block

`timescale 1ns / 1ps
`default_nettype none

package spm_pkg;

    // sample and magnitude widths
    localparam int SAMPLE_BITS = 24;
    localparam int MAG_W       = SAMPLE_BITS - 1;

    // block length counter
    localparam int MAX_BLOCK = 4096;
    localparam int CNT_W     = $clog2(MAX_BLOCK + 1);

    // levels in dB, signed Q8.8
    localparam int                        LEVEL_W      = 16;
    localparam logic signed [LEVEL_W-1:0] DB_FLOOR     = -16'sd25600;
    localparam int                        DB_FLOOR_MAG = 25600;

    // log2 by repeated squaring
    localparam int NORM_W        = 32;
    localparam int NORM_STEPS    = $clog2(NORM_W);
    localparam int LZ_W          = $clog2(NORM_W);
    localparam int NORM_OFFSET   = NORM_W - SAMPLE_BITS;
    localparam int LOG_FRAC_BITS = 24;
    localparam int STEP_W        = $clog2(LOG_FRAC_BITS);
    localparam int M_W           = LZ_W + LOG_FRAC_BITS;

    // 20*log10(2)*256 in Q.16
    localparam int                   DB_COEF_W       = 27;
    localparam logic [DB_COEF_W-1:0] DB_PER_LOG2_Q16 = 27'd101008905;
    localparam int                   DB_PROD_W       = M_W + DB_COEF_W;
    localparam int                   DB_SHIFT        = LOG_FRAC_BITS + 16;

    // configuration
    localparam int COEF_W      = 16;
    localparam int HOLD_W      = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_COEF = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_LENGTH  = 1'd1;

    localparam logic [COEF_W-1:0] RELEASE_COEF_RESET = 16'd2293;
    localparam logic [HOLD_W-1:0] HOLD_LENGTH_RESET  = 24'd72000;

    // envelope release product, magnitude of a level difference times coefficient
    localparam int DIFF_W     = LEVEL_W - 1;
    localparam int ENV_PROD_W = DIFF_W + COEF_W;

    // queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int CHANNELS = 2;

    // one finished block as handed from front to back
    typedef struct packed {
        logic [MAG_W-1:0] peak_l;
        logic [MAG_W-1:0] peak_r;
        logic [CNT_W-1:0] count;
    } block_t;

endpackage

`default_nettype wire

// File: rtl/spm_if.sv
// spm_if: request channels of the meter, samples in and levels out
// depends on spm_pkg for field widths

`timescale 1ns / 1ps
`default_nettype none

interface spm_sample_if import spm_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
    logic                          right_present;
    logic                          last_in_block;

    modport source (
        output valid, left_sample, right_sample, right_present, last_in_block,
        input  ready
    );
    modport sink (
        input  valid, left_sample, right_sample, right_present, last_in_block,
        output ready
    );
endinterface

interface spm_level_if import spm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] env_left_db;
    logic signed [LEVEL_W-1:0] env_right_db;
    logic signed [LEVEL_W-1:0] hold_left_db;
    logic signed [LEVEL_W-1:0] hold_right_db;

    modport source (
        output valid, env_left_db, env_right_db, hold_left_db, hold_right_db,
        input  ready
    );
    modport sink (
        input  valid, env_left_db, env_right_db, hold_left_db, hold_right_db,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/stereo_peak_hold_meter_unit.sv
// stereo_peak_hold_meter_unit: top level of the stereo peak-hold level meter
// depends on spm_pkg, spm_if, spm_front, spm_fifo, spm_back (with spm_log)
//
//  channel   dir  request          payload
//  samples   in   valid / ready    left_sample, right_sample, right_present, last_in_block
//  levels    out  valid / ready    env_left_db, env_right_db, hold_left_db, hold_right_db
//  cfg       in   cfg_we           cfg_index, cfg_data (no read-back)
//
// samples are taken one per cycle while the two-entry block queue has room
// each block's time in the back end is set mostly by the 24 squaring
// steps of the per-channel log2 unit; blocks shorter than that time fill the queue
// and hold samples.ready low until a block leaves
// a result passes the queue, the log2 units and the envelope update to the output register
// reset clears control, peak, envelope and hold state at once, no clearing
// pass; a stalled levels request holds the back end, so the queue fills and samples stall

`timescale 1ns / 1ps
`default_nettype none

module stereo_peak_hold_meter_unit import spm_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    spm_sample_if.sink                  samples,
    spm_level_if.source                 levels,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic   push;
    logic   full;
    logic   pop;
    logic   empty;
    block_t push_data;
    block_t pop_data;

    spm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    spm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .pop_data  (pop_data)
    );

    spm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop_data  (pop_data),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .levels    (levels)
    );

endmodule

`default_nettype wire

// File: rtl/spm_front.sv
// spm_front: takes sample requests, tracks per-channel peaks and the block count
// depends on spm_pkg and spm_sample_if; pushes finished blocks to spm_fifo

`timescale 1ns / 1ps
`default_nettype none

module spm_front import spm_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    spm_sample_if.sink  samples,
    output logic        push,
    output block_t      push_data,
    input  wire logic   full
);

    logic [MAG_W-1:0] peak_l_reg, peak_l_next;
    logic [MAG_W-1:0] peak_r_reg, peak_r_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0] mag_l, mag_r;
    logic             accept;

    // absolute value, most negative code saturates
    function automatic logic [MAG_W-1:0] magnitude(input logic [SAMPLE_BITS-1:0] raw);
        logic [SAMPLE_BITS-1:0] neg;
        begin
            neg = ~raw + 1'b1;
            if (!raw[SAMPLE_BITS-1])
                magnitude = raw[MAG_W-1:0];
            else if (neg[SAMPLE_BITS-1])
                magnitude = {MAG_W{1'b1}};
            else
                magnitude = neg[MAG_W-1:0];
        end
    endfunction

    assign samples.ready = !full;
    assign accept        = samples.valid && !full;

    assign mag_l = magnitude(samples.left_sample);
    assign mag_r = samples.right_present ? magnitude(samples.right_sample) : mag_l;

    always_comb
    begin
        peak_l_next = (mag_l > peak_l_reg) ? mag_l : peak_l_reg;
        peak_r_next = (mag_r > peak_r_reg) ? mag_r : peak_r_reg;
        cnt_next    = (cnt_reg < CNT_W'(MAX_BLOCK)) ? cnt_reg + 1'b1 : cnt_reg;
    end

    assign push             = accept && samples.last_in_block;
    assign push_data.peak_l = peak_l_next;
    assign push_data.peak_r = peak_r_next;
    assign push_data.count  = cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_l_reg <= '0;
            peak_r_reg <= '0;
            cnt_reg    <= '0;
        end
        else if (accept)
        begin
            if (samples.last_in_block)
            begin
                peak_l_reg <= '0;
                peak_r_reg <= '0;
                cnt_reg    <= '0;
            end
            else
            begin
                peak_l_reg <= peak_l_next;
                peak_r_reg <= peak_r_next;
                cnt_reg    <= cnt_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/spm_fifo.sv
// spm_fifo: short queue of finished blocks between front and back
// depends on spm_pkg for block_t and the queue depth

`timescale 1ns / 1ps
`default_nettype none

module spm_fifo import spm_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire block_t push_data,
    output logic        full,
    input  wire logic   pop,
    output logic        empty,
    output block_t      pop_data
);

    block_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// File: rtl/spm_log.sv
// spm_log: peak magnitude to dB in Q8.8, normalise then log2 by repeated squaring
// depends on spm_pkg; one instance per channel inside spm_back

`timescale 1ns / 1ps
`default_nettype none

module spm_log import spm_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [MAG_W-1:0]     peak,
    output logic                      done,
    output logic signed [LEVEL_W-1:0] level
);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_NORM = 3'd1;
    localparam logic [2:0] L_SQR  = 3'd2;
    localparam logic [2:0] L_DIFF = 3'd3;
    localparam logic [2:0] L_MUL  = 3'd4;
    localparam logic [2:0] L_RND  = 3'd5;

    localparam int Q_W = DB_PROD_W + 1 - DB_SHIFT;

    logic [2:0]                state_reg, state_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      done_reg, done_next;
    logic [NORM_W-1:0]         x_reg, x_next;
    logic [LZ_W-1:0]           lz_reg, lz_next;
    logic                      zero_reg, zero_next;
    logic [LOG_FRAC_BITS-1:0]  frac_reg, frac_next;
    logic [M_W-1:0]            m_reg, m_next;
    logic [DB_PROD_W-1:0]      prod_reg, prod_next;
    logic signed [LEVEL_W-1:0] level_reg, level_next;

    logic [LZ_W-1:0]        norm_sh;
    logic [NORM_W-1:0]      hi_mask;
    logic [2*NORM_W-1:0]    sq;
    logic [NORM_W:0]        sq_top;
    logic [DB_PROD_W:0]     rnd_sum;
    logic [Q_W-1:0]         q;

    assign norm_sh = LZ_W'(NORM_W / 2) >> step_reg;
    assign hi_mask = ~({NORM_W{1'b1}} >> norm_sh);
    assign sq      = (2*NORM_W)'(x_reg) * (2*NORM_W)'(x_reg);
    assign sq_top  = sq[2*NORM_W-1:NORM_W-1];
    assign rnd_sum = {1'b0, prod_reg} + (DB_PROD_W+1)'((64'd1 << DB_SHIFT) - 64'd1);
    assign q       = rnd_sum[DB_PROD_W:DB_SHIFT];

    assign done  = done_reg;
    assign level = level_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        lz_next    = lz_reg;
        zero_next  = zero_reg;
        frac_next  = frac_reg;
        m_next     = m_reg;
        prod_next  = prod_reg;
        level_next = level_reg;
        unique case (state_reg)
            L_IDLE:
            begin
                if (start)
                begin
                    x_next     = NORM_W'(peak);
                    zero_next  = (peak == '0);
                    lz_next    = '0;
                    step_next  = '0;
                    state_next = L_NORM;
                end
            end
            L_NORM:
            begin
                if ((x_reg & hi_mask) == '0)
                begin
                    x_next  = x_reg << norm_sh;
                    lz_next = lz_reg + norm_sh;
                end
                if (step_reg == STEP_W'(NORM_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = L_SQR;
                end
                else
                    step_next = step_reg + 1'b1;
            end
            L_SQR:
            begin
                x_next    = sq_top[NORM_W] ? sq_top[NORM_W:1] : sq_top[NORM_W-1:0];
                frac_next = {frac_reg[LOG_FRAC_BITS-2:0], sq_top[NORM_W]};
                if (step_reg == STEP_W'(LOG_FRAC_BITS - 1))
                    state_next = L_DIFF;
                else
                    step_next = step_reg + 1'b1;
            end
            L_DIFF:
            begin
                m_next     = {lz_reg - LZ_W'(NORM_OFFSET), {LOG_FRAC_BITS{1'b0}}}
                             - M_W'(frac_reg);
                state_next = L_MUL;
            end
            L_MUL:
            begin
                prod_next  = DB_PROD_W'(m_reg) * DB_PROD_W'(DB_PER_LOG2_Q16);
                state_next = L_RND;
            end
            L_RND:
            begin
                if (zero_reg || q > Q_W'(DB_FLOOR_MAG))
                    level_next = DB_FLOOR;
                else
                    level_next = -$signed({1'b0, q[LEVEL_W-2:0]});
                done_next  = 1'b1;
                state_next = L_IDLE;
            end
            default:
                state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        lz_reg    <= lz_next;
        zero_reg  <= zero_next;
        frac_reg  <= frac_next;
        m_reg     <= m_next;
        prod_reg  <= prod_next;
        level_reg <= level_next;
    end

endmodule

`default_nettype wire

// File: rtl/spm_back.sv
// spm_back: per block, dB conversion, envelope release, peak hold and result register
// depends on spm_pkg, spm_level_if and spm_log; pops blocks from spm_fifo

`timescale 1ns / 1ps
`default_nettype none

module spm_back import spm_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   empty,
    input  wire block_t                 pop_data,
    output logic                        pop,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    spm_level_if.source                 levels
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOG  = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [COEF_W-1:0]   release_coef_reg;
    logic [HOLD_W-1:0]   hold_length_reg;
    logic [CNT_W-1:0]    n_reg;
    logic                out_valid_reg, out_valid_next;
    logic                commit;

    logic signed [LEVEL_W-1:0] env_reg   [CHANNELS];
    logic signed [LEVEL_W-1:0] env_next  [CHANNELS];
    logic signed [LEVEL_W-1:0] held_reg  [CHANNELS];
    logic signed [LEVEL_W-1:0] held_next [CHANNELS];
    logic [HOLD_W-1:0]         cnt_reg   [CHANNELS];
    logic [HOLD_W-1:0]         cnt_next  [CHANNELS];
    logic [HOLD_W-1:0]         cnt_dec   [CHANNELS];
    logic [ENV_PROD_W-1:0]     prod_reg  [CHANNELS];
    logic                      rise_reg  [CHANNELS];
    logic signed [LEVEL_W-1:0] diff      [CHANNELS];
    logic [ENV_PROD_W:0]       dec_sum   [CHANNELS];
    logic [LEVEL_W-1:0]        dec       [CHANNELS];
    logic signed [LEVEL_W-1:0] out_env_reg  [CHANNELS];
    logic signed [LEVEL_W-1:0] out_held_reg [CHANNELS];

    logic [MAG_W-1:0]          peak_in   [CHANNELS];
    logic                      log_done  [CHANNELS];
    logic signed [LEVEL_W-1:0] level     [CHANNELS];

    assign peak_in[0] = pop_data.peak_l;
    assign peak_in[1] = pop_data.peak_r;

    assign pop    = (state_reg == S_IDLE) && !empty;
    assign commit = (state_reg == S_UPD) && (!out_valid_reg || levels.ready);

    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_ch
        spm_log u_log (
            .clk   (clk),
            .rst_n (rst_n),
            .start (pop),
            .peak  (peak_in[ch]),
            .done  (log_done[ch]),
            .level (level[ch])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (!empty)                     state_next = S_LOG;
            S_LOG:  if (log_done[0] && log_done[1]) state_next = S_MUL;
            S_MUL:                                  state_next = S_UPD;
            S_UPD:  if (commit)                     state_next = S_IDLE;
        endcase
    end

    // envelope release and hold, channels side by side
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            diff[ch]    = env_reg[ch] - level[ch];
            dec_sum[ch] = {1'b0, prod_reg[ch]} + (ENV_PROD_W+1)'((1 << COEF_W) - 1);
            dec[ch]     = dec_sum[ch][ENV_PROD_W:COEF_W];
            env_next[ch] = rise_reg[ch] ? level[ch] : env_reg[ch] - $signed(dec[ch]);
            cnt_dec[ch]  = (cnt_reg[ch] > HOLD_W'(n_reg)) ? cnt_reg[ch] - HOLD_W'(n_reg)
                                                         : '0;
            if (level[ch] >= held_reg[ch])
            begin
                held_next[ch] = level[ch];
                cnt_next[ch]  = hold_length_reg;
            end
            else
            begin
                cnt_next[ch]  = cnt_dec[ch];
                held_next[ch] = (cnt_dec[ch] == '0) ? env_next[ch] : held_reg[ch];
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !levels.ready;
        if (commit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            release_coef_reg <= RELEASE_COEF_RESET;
            hold_length_reg  <= HOLD_LENGTH_RESET;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                env_reg[ch]  <= DB_FLOOR;
                held_reg[ch] <= DB_FLOOR;
                cnt_reg[ch]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RELEASE_COEF: release_coef_reg <= cfg_data[COEF_W-1:0];
                    CFG_HOLD_LENGTH:  hold_length_reg  <= cfg_data[HOLD_W-1:0];
                endcase
            end
            if (commit)
            begin
                for (int ch = 0; ch < CHANNELS; ch++)
                begin
                    env_reg[ch]  <= env_next[ch];
                    held_reg[ch] <= held_next[ch];
                    cnt_reg[ch]  <= cnt_next[ch];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            n_reg <= pop_data.count;
        if (state_reg == S_MUL)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                rise_reg[ch] <= level[ch] > env_reg[ch];
                prod_reg[ch] <= ENV_PROD_W'(diff[ch][DIFF_W-1:0])
                                * ENV_PROD_W'(release_coef_reg);
            end
        end
        if (commit)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                out_env_reg[ch]  <= env_next[ch];
                out_held_reg[ch] <= held_next[ch];
            end
        end
    end

    assign levels.valid         = out_valid_reg;
    assign levels.env_left_db   = out_env_reg[0];
    assign levels.env_right_db  = out_env_reg[1];
    assign levels.hold_left_db  = out_held_reg[0];
    assign levels.hold_right_db = out_held_reg[1];

endmodule

`default_nettype wire

// File: rtl/spm_checker.sv
// spm_checker: port-level assertions for the meter, bound to the top level
// depends on spm_pkg; watches the levels channel and reset

`timescale 1ns / 1ps
`default_nettype none

module spm_checker import spm_pkg::*; (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      levels_valid,
    input wire logic                      levels_ready,
    input wire logic signed [LEVEL_W-1:0] env_left_db,
    input wire logic signed [LEVEL_W-1:0] env_right_db,
    input wire logic signed [LEVEL_W-1:0] hold_left_db,
    input wire logic signed [LEVEL_W-1:0] hold_right_db
);

    // stalled result stays put
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        levels_valid && !levels_ready |=> levels_valid && $stable(env_left_db)
            && $stable(env_right_db) && $stable(hold_left_db) && $stable(hold_right_db))
        else $error("levels request changed while stalled");

    // levels never above full scale or below the floor
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        levels_valid |-> env_left_db <= 16'sd0 && env_left_db >= DB_FLOOR
            && env_right_db <= 16'sd0 && env_right_db >= DB_FLOOR
            && hold_left_db <= 16'sd0 && hold_left_db >= DB_FLOOR
            && hold_right_db <= 16'sd0 && hold_right_db >= DB_FLOOR)
        else $error("level outside floor to full scale");

    // no result shown while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !levels_valid)
        else $error("levels valid during reset");

endmodule

bind stereo_peak_hold_meter_unit spm_checker u_spm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .levels_valid  (levels.valid),
    .levels_ready  (levels.ready),
    .env_left_db   (levels.env_left_db),
    .env_right_db  (levels.env_right_db),
    .hold_left_db  (levels.hold_left_db),
    .hold_right_db (levels.hold_right_db)
);

`default_nettype wire
